// ----- rtl/core/fir9u3_pkg.sv -----
// Shared types and constants of the unfolded 9-tap FIR filter.
`default_nettype none
package fir9u3_pkg;

  localparam int TAPS        = 9;
  localparam int LANES       = 3;
  localparam int SAMPLE_BITS = 11;
  localparam int DATA_BITS   = 8;
  localparam int HIST        = TAPS - 1;
  localparam int WINDOW      = TAPS - 1 + LANES;
  localparam int COEF_BITS   = 7;
  localparam int PROD_BITS   = DATA_BITS + COEF_BITS;
  localparam int PROD_SHIFT  = DATA_BITS - 1;
  localparam int TERM_BITS   = PROD_BITS - 1 - PROD_SHIFT;
  localparam int SUM_BITS    = 11;
  localparam int OUT_BITS    = 12;
  localparam int OUT_SHIFT   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DATA_BITS-1:0]   smp_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [TERM_BITS-1:0]   term_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic signed [OUT_BITS-1:0]    result_t;

  typedef smp_t  [TAPS-1:0]  tap_win_t;
  typedef term_t [TAPS-1:0]  lane_terms_t;
  typedef smp_t  [HIST-1:0]  hist_t;

  // Coefficients {-7,-14,52,272,415,...} floored by a shift right of 3.
  localparam coef_t COEF [TAPS] = '{
    -7'sd1, -7'sd2, 7'sd6, 7'sd34, 7'sd51, 7'sd34, 7'sd6, -7'sd2, -7'sd1
  };

endpackage
`default_nettype wire

// ----- rtl/core/fir9u3_if.sv -----
// Valid/ready channel interfaces for the input samples and the filter outputs.
`default_nettype none
interface fir9u3_in_if;
  import fir9u3_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_first;
  sample_t sample_second;
  sample_t sample_third;

  modport source (output valid, output sample_first, output sample_second,
                  output sample_third, input ready);
  modport sink   (input valid, input sample_first, input sample_second,
                  input sample_third, output ready);
endinterface

interface fir9u3_out_if;
  import fir9u3_pkg::*;

  logic    valid;
  logic    ready;
  result_t out_first;
  result_t out_second;
  result_t out_third;

  modport source (output valid, output out_first, output out_second,
                  output out_third, input ready);
  modport sink   (input valid, input out_first, input out_second,
                  input out_third, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fir9u3_lane.sv -----
// One filter lane: nine constant-coefficient products, floored and registered.
`default_nettype none
module fir9u3_lane (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  fir9u3_pkg::tap_win_t    taps_i,
  output fir9u3_pkg::lane_terms_t terms_o
);
  import fir9u3_pkg::*;

  lane_terms_t terms_d;
  lane_terms_t terms_q;

  always_comb begin
    prod_t p;
    for (int i = 0; i < TAPS; i++) begin
      p = prod_t'(taps_i[i]) * prod_t'(COEF[i]);
      // arithmetic shift right = floor; value fits the term width
      terms_d[i] = p[PROD_BITS-2:PROD_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      terms_q <= terms_d;
    end
  end

  assign terms_o = terms_q;

endmodule
`default_nettype wire

// ----- rtl/core/fir9u3_merge.sv -----
// Merge stage: sums each lane's terms, scales, and holds the output transaction.
`default_nettype none
module fir9u3_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s1_valid_i,
  input  fir9u3_pkg::lane_terms_t terms_i [fir9u3_pkg::LANES],
  output logic                    adv_o,
  fir9u3_out_if.source            out_o
);
  import fir9u3_pkg::*;

  logic    out_valid_q;
  result_t res_d [LANES];
  result_t res_q [LANES];

  always_comb begin
    sum_t acc;
    for (int j = 0; j < LANES; j++) begin
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
        acc = acc + sum_t'(terms_i[j][i]);
      end
      // times 8, kept to the output width
      res_d[j] = {acc[OUT_BITS-OUT_SHIFT-1:0], {OUT_SHIFT{1'b0}}};
    end
  end

  assign adv_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_first  = res_q[0];
  assign out_o.out_second = res_q[1];
  assign out_o.out_third  = res_q[2];

endmodule
`default_nettype wire

// ----- rtl/core/fir9_unfolded3_eight_bit.sv -----
// Top level of the 9-tap low-pass FIR filter unfolded by three lanes.
//
//  channel | dir | payload                                    | handshake
//  in_i    | in  | sample_first/second/third, 11b signed      | valid/ready
//  out_o   | out | out_first/second/third, 12b signed         | valid/ready
//
// Takes one transaction (three samples) per cycle while the output is not stalled;
// the pipeline is the lane product registers, then the merge adder and output register.
// Reset clears the eight-sample history to zero and empties the pipeline.
// A stalled output holds; input is still taken while the lane stage is free.
`default_nettype none
module fir9_unfolded3_eight_bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  fir9u3_in_if.sink   in_i,
  fir9u3_out_if.source out_o
);
  import fir9u3_pkg::*;

  hist_t       hist_q;
  hist_t       hist_d;
  smp_t        win [WINDOW];
  tap_win_t    lane_win [LANES];
  lane_terms_t lane_terms [LANES];
  logic        s1_valid_q;
  logic        adv;
  logic        accept;

  assign in_i.ready = !s1_valid_q || adv;
  assign accept     = in_i.valid && in_i.ready;

  // win[0] is the newest reduced sample; floor shift right by 3 is a part-select
  always_comb begin
    win[0] = in_i.sample_third[SAMPLE_BITS-1:SAMPLE_BITS-DATA_BITS];
    win[1] = in_i.sample_second[SAMPLE_BITS-1:SAMPLE_BITS-DATA_BITS];
    win[2] = in_i.sample_first[SAMPLE_BITS-1:SAMPLE_BITS-DATA_BITS];
    for (int k = 0; k < HIST; k++) begin
      win[LANES+k] = hist_q[k];
    end
    for (int j = 0; j < LANES; j++) begin
      for (int i = 0; i < TAPS; i++) begin
        lane_win[j][i] = win[i+LANES-1-j];
      end
    end
    for (int k = 0; k < HIST; k++) begin
      hist_d[k] = win[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        hist_q <= hist_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    fir9u3_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (accept),
      .taps_i  (lane_win[j]),
      .terms_o (lane_terms[j])
    );
  end

  fir9u3_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .terms_i    (lane_terms),
    .adv_o      (adv),
    .out_o      (out_o)
  );

`ifndef SYNTH
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction did not reach the lane stage");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q)
    else $error("lane stage dropped a transaction under stall");

  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> hist_q[LANES] == $past(hist_q[0]))
    else $error("history did not shift by three samples");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(s1_valid_q))
    else $error("output valid without a lane-stage transaction");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_fir9_unfolded3_eight_bit.sv -----
// Self-checking testbench for the three-lane 9-tap low-pass FIR filter.
`timescale 1ns / 100ps
module tb_fir9_unfolded3_eight_bit;
  import fir9u3_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_TAIL   = 200;
  localparam int SETTLE_CYC   = 8;
  localparam int N_ROWS       = 22;

  // Coefficients after the shift right by three.
  localparam int TAP_WEIGHT [9] = '{-1, -2, 6, 34, 51, 34, 6, -2, -1};

  typedef struct packed {
    result_t first;
    result_t second;
    result_t third;
  } out_triple_t;

  typedef struct packed {
    sample_t     a;
    sample_t     b;
    sample_t     c;
    logic        fixed;
    out_triple_t want;
  } stim_row_t;

  typedef enum int {PAT_ANY, PAT_EXTREME, PAT_SMALL, PAT_HOLD, PAT_SWING} pattern_t;

  logic clk_i;
  logic rst_ni;

  fir9u3_in_if  in_ch ();
  fir9u3_out_if out_ch ();

  fir9_unfolded3_eight_bit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  smp_t        tap_history [HIST];
  out_triple_t pending_outputs [$];
  logic        row_fixed;
  out_triple_t row_want;
  bit          quiet;
  int          err_count;
  int          items_taken;
  int          outputs_checked;

  always begin
    clk_i = 1'b1;
    #(HALF_PERIOD);
    clk_i = 1'b0;
    #(HALF_PERIOD);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Runs one transaction through the filter model and shifts the history.
  function automatic out_triple_t filter_lanes(input sample_t s0, input sample_t s1,
                                               input sample_t s2);
    smp_t        win [WINDOW];
    int          acc;
    int          lane;
    out_triple_t res;
    // win[0] is the newest reduced sample
    win[0] = smp_t'(s2 >>> 3);
    win[1] = smp_t'(s1 >>> 3);
    win[2] = smp_t'(s0 >>> 3);
    for (int k = 0; k < HIST; k++) win[LANES + k] = tap_history[k];
    for (lane = 0; lane < LANES; lane++) begin
      acc = 0;
      for (int t = 0; t < TAPS; t++)
        acc += (int'(win[t + LANES - 1 - lane]) * TAP_WEIGHT[t]) >>> 7;
      acc = acc * 8;
      case (lane)
        0: res.first  = result_t'(acc);
        1: res.second = result_t'(acc);
        default: res.third = result_t'(acc);
      endcase
    end
    for (int k = 0; k < HIST; k++) tap_history[k] = win[k];
    return res;
  endfunction

  function automatic sample_t rand_sample(input pattern_t pat, input sample_t level);
    case (pat)
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(1023);
          1: return sample_t'(-1024);
          2: return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      PAT_SMALL: return sample_t'(int'($urandom_range(0, 31)) - 16);
      PAT_HOLD:  return level;
      PAT_SWING: begin
        if ($urandom_range(0, 1)) return sample_t'(1023 - int'($urandom_range(0, 7)));
        else return sample_t'(-1024 + int'($urandom_range(0, 7)));
      end
      default: return sample_t'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic send_triple(input sample_t a, input sample_t b, input sample_t c,
                             input logic fixed, input out_triple_t want);
    @(negedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.sample_first  <= a;
    in_ch.sample_second <= b;
    in_ch.sample_third  <= c;
    row_fixed           <= fixed;
    row_want            <= want;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Input side idles; payload keeps toggling while valid is low.
  task automatic hold_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_ch.valid         <= 1'b0;
      in_ch.sample_first  <= sample_t'($urandom_range(0, 2047));
      in_ch.sample_second <= sample_t'($urandom_range(0, 2047));
      in_ch.sample_third  <= sample_t'($urandom_range(0, 2047));
    end
  endtask

  task automatic drain_outputs();
    hold_input(1);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // Scoreboard: both channels sampled at the rising edge.
  always @(posedge clk_i) begin : scoreboard
    out_triple_t calc;
    out_triple_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        calc = filter_lanes(in_ch.sample_first, in_ch.sample_second, in_ch.sample_third);
        pending_outputs.push_back(row_fixed ? row_want : calc);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        outputs_checked++;
        if (pending_outputs.size() == 0) begin
          report_mismatch("output transaction with nothing pending");
        end else begin
          want = pending_outputs.pop_front();
          if (out_ch.out_first !== want.first)
            report_mismatch($sformatf("out_first got %0d want %0d",
                                      out_ch.out_first, want.first));
          if (out_ch.out_second !== want.second)
            report_mismatch($sformatf("out_second got %0d want %0d",
                                      out_ch.out_second, want.second));
          if (out_ch.out_third !== want.third)
            report_mismatch($sformatf("out_third got %0d want %0d",
                                      out_ch.out_third, want.third));
        end
      end
    end
  end

  // Output back-pressure in random bursts; always ready once quiet.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 15)) begin
          @(negedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 40)) begin
          @(negedge clk_i);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("timeout: %0d transactions still pending", pending_outputs.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t   rows [N_ROWS];
    out_triple_t none;
    pattern_t    pat;
    sample_t     level;
    int          sent;
    int          seg;
    bit          gaps;
    bit          drained_mid;

    none = '0;
    // After reset: empty history gives zero out.
    rows[0]  = '{11'sd0, 11'sd0, 11'sd0, 1'b1, '{12'sd0, 12'sd0, 12'sd0}};
    // Full-scale positive until the window is full.
    rows[1]  = '{11'sd1023, 11'sd1023, 11'sd1023, 1'b0, none};
    rows[2]  = '{11'sd1023, 11'sd1023, 11'sd1023, 1'b0, none};
    rows[3]  = '{11'sd1023, 11'sd1023, 11'sd1023, 1'b0, none};
    rows[4]  = '{11'sd1023, 11'sd1023, 11'sd1023, 1'b1, '{12'sd960, 12'sd960, 12'sd960}};
    // Full-scale negative step.
    rows[5]  = '{-11'sd1024, -11'sd1024, -11'sd1024, 1'b0, none};
    rows[6]  = '{-11'sd1024, -11'sd1024, -11'sd1024, 1'b0, none};
    rows[7]  = '{-11'sd1024, -11'sd1024, -11'sd1024, 1'b0, none};
    rows[8]  = '{-11'sd1024, -11'sd1024, -11'sd1024, 1'b1,
                 '{-12'sd1000, -12'sd1000, -12'sd1000}};
    // Positive then negative impulse, each followed by zeros to walk it through every tap.
    rows[9]  = '{11'sd1023, 11'sd0, 11'sd0, 1'b0, none};
    rows[10] = '{11'sd0, 11'sd0, 11'sd0, 1'b0, none};
    rows[11] = '{11'sd0, 11'sd0, 11'sd0, 1'b0, none};
    rows[12] = '{11'sd0, 11'sd0, 11'sd0, 1'b0, none};
    rows[13] = '{-11'sd1024, 11'sd0, 11'sd0, 1'b0, none};
    rows[14] = '{11'sd0, 11'sd0, 11'sd0, 1'b0, none};
    rows[15] = '{11'sd0, 11'sd0, 11'sd0, 1'b0, none};
    // Values around the rounding step of the input reduction.
    rows[16] = '{11'sd7, -11'sd1, -11'sd8, 1'b0, none};
    rows[17] = '{11'sd8, -11'sd9, 11'sd1016, 1'b0, none};
    rows[18] = '{-11'sd1017, 11'sd15, -11'sd16, 1'b0, none};
    // Largest swing between neighbors.
    rows[19] = '{11'sd1023, -11'sd1024, 11'sd1023, 1'b0, none};
    rows[20] = '{-11'sd1024, 11'sd1023, -11'sd1024, 1'b0, none};
    rows[21] = '{11'sd1023, -11'sd1024, 11'sd1023, 1'b0, none};

    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.sample_first  = '0;
    in_ch.sample_second = '0;
    in_ch.sample_third  = '0;
    row_fixed           = 1'b0;
    row_want            = '0;
    quiet               = 1'b0;
    err_count           = 0;
    items_taken         = 0;
    outputs_checked     = 0;
    drained_mid         = 1'b0;
    for (int k = 0; k < HIST; k++) tap_history[k] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[r]) begin
      if (r % 5 == 4) hold_input($urandom_range(1, 15));
      send_triple(rows[r].a, rows[r].b, rows[r].c, rows[r].fixed, rows[r].want);
    end
    drain_outputs();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pat   = pattern_t'($urandom_range(0, 4));
      seg   = $urandom_range(1, 40);
      level = sample_t'($urandom_range(0, 2047));
      gaps  = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < seg && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
        if (!quiet && gaps && $urandom_range(0, 5) == 0)
          hold_input($urandom_range(1, 15));
        send_triple(rand_sample(pat, level), rand_sample(pat, level),
                    rand_sample(pat, level), 1'b0, none);
        sent++;
        if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
          drain_outputs();
          drained_mid = 1'b1;
        end
      end
    end

    drain_outputs();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("covered %0d input transactions (%0d directed, rest random patterns)",
             items_taken, N_ROWS);
    $display("checked %0d output transactions, %0d mismatches", outputs_checked, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
